// File: rtl/core/assert_macros.svh
// ============================================================================
// assert_macros.svh
// assertion macros shared by the extended community set engine
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ECSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define ECSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next cycle check failed");

`endif

// File: rtl/core/ecse_pkg.sv
// ============================================================================
// ecse_pkg
// command codes, status codes and shared types of the community set engine
// ============================================================================
package ecse_pkg;

    localparam int CMD_W    = 3;
    localparam int COMM_W   = 64;
    localparam int IDX_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam int NONTRANS_POS = 62;

    localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STRIP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SORT     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic eq;
        logic gt;
        logic nontrans;
    } cmp_t;

    typedef struct packed {
        logic                found;
        logic [STATUS_W-1:0] status;
        logic [COMM_W-1:0]   entry;
    } res_t;

endpackage

// File: rtl/core/extended_community_set_engine.sv
// ============================================================================
// extended_community_set_engine
// ordered set of 64-bit extended communities driven by one command per request
// ============================================================================
// One request is worked at a time; s_axis_tready is low while a command runs.
// Contains, add, delete and strip scan every held entry: one sequencer
// walks the entry memory one entry per cycle through a single read port and
// one shared 64-bit compare unit; add then appends in S_ADD when the entry
// is absent and room remains. Read checks the index and then fetches the
// entry; clear and unused codes go straight to the result. Sort is an
// in-place insertion sort over the same memory port and compare unit. A
// result waits in an output register, so the next request is taken while it
// is still held on the master side.
`include "assert_macros.svh"

module extended_community_set_engine #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // community[63:0], index[68:64], zero fill
    input  logic [2:0]  s_axis_tuser,   // command[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // found[0], count[6:1], entry[70:7], status[72:71]
);
    import ecse_pkg::*;

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int OUT_W  = 1 + COUNT_W + COMM_W + STATUS_W;
    localparam int TDATA_W = 80;

    logic                res_valid;
    logic                res_ready;
    res_t                res;
    logic [CW-1:0]       res_count;
    logic                out_valid_reg;
    logic [TDATA_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]    out_data_next;
    logic                full_drop;

    ecse_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req_cmd   (s_axis_tuser),
        .req_comm  (s_axis_tdata[COMM_W-1:0]),
        .req_idx   (s_axis_tdata[COMM_W+IDX_W-1:COMM_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .res_count (res_count)
    );

    assign res_ready     = !out_valid_reg || m_axis_tready;
    assign out_data_next = {res.status, res.entry, COUNT_W'(res_count), res.found};
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign full_drop     = res_valid && (res.status == ST_FULL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= TDATA_W'(out_data_next);
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `ECSE_ASSERT_IMP(a_count_bound, clk, rst_n, res_valid, res_count <= CW'(CAPACITY))
    `ECSE_ASSERT_IMP(a_full_drop, clk, rst_n, full_drop, !res.found && (res_count == CW'(CAPACITY)))
    `ECSE_ASSERT_NXT(a_busy_after_req, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

// File: rtl/core/ecse_cmp.sv
// ============================================================================
// ecse_cmp
// shared 64-bit compare unit: equality, unsigned greater-than, transitivity
// ============================================================================
module ecse_cmp (
    input  logic [ecse_pkg::COMM_W-1:0] a,
    input  logic [ecse_pkg::COMM_W-1:0] b,
    output ecse_pkg::cmp_t              result
);
    import ecse_pkg::*;

    always_comb
    begin
        result.eq       = (a == b);
        result.gt       = (a > b);
        result.nontrans = a[NONTRANS_POS];
    end

endmodule

// File: rtl/core/ecse_core.sv
// ============================================================================
// ecse_core
// command sequencer with the entry memory and the shared compare unit
// ============================================================================
module ecse_core #(
    parameter int CAPACITY = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  logic [ecse_pkg::CMD_W-1:0]      req_cmd,
    input  logic [ecse_pkg::COMM_W-1:0]     req_comm,
    input  logic [ecse_pkg::IDX_W-1:0]      req_idx,
    output logic                            res_valid,
    input  logic                            res_ready,
    output ecse_pkg::res_t                  res,
    output logic [$clog2(CAPACITY+1)-1:0]   res_count
);
    import ecse_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ADD,
        S_READ,
        S_READ_DATA,
        S_SORT_KEY,
        S_SORT_LOAD,
        S_SORT_CMP,
        S_SORT_PLACE,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [COMM_W-1:0]   comm_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       r_reg;
    logic [CW-1:0]       w_reg;
    logic [CW-1:0]       i_reg;
    logic [CW-1:0]       j_reg;
    logic                pend_reg;
    logic                found_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COMM_W-1:0]   entry_reg;
    logic [COMM_W-1:0]   rd_data_reg;

    logic [COMM_W-1:0] mem [CAPACITY];

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [COMM_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    cmp_t              cmp;
    logic              keep;
    logic              issue;
    logic [CMPW-1:0]   idx_w;
    logic              idx_ok;
    logic [CW-1:0]     i_dec;
    logic [CW-1:0]     j_dec;
    logic [CW-1:0]     j_dec2;

    ecse_cmp u_cmp (
        .a      (rd_data_reg),
        .b      (comm_reg),
        .result (cmp)
    );

    assign keep   = ((cmd_reg == CMD_DELETE) && !cmp.eq)
                 || ((cmd_reg == CMD_STRIP) && !cmp.nontrans);
    assign issue  = (r_reg < count_reg);
    assign idx_w  = CMPW'(idx_reg);
    assign idx_ok = (idx_w < CMPW'(count_reg));
    assign i_dec  = i_reg - CW'(1);
    assign j_dec  = j_reg - CW'(1);
    assign j_dec2 = j_reg - CW'(2);

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.found  = found_reg;
    assign res.status = status_reg;
    assign res.entry  = entry_reg;
    assign res_count  = count_reg;

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = rd_data_reg;
        mem_raddr = '0;
        unique case (state_reg)
            S_SCAN:
            begin
                if (issue)
                begin
                    mem_raddr = r_reg[AW-1:0];
                end
                if (pend_reg && keep)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = w_reg[AW-1:0];
                end
            end
            S_ADD:
            begin
                if (!found_reg && (count_reg < CAP_C))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = count_reg[AW-1:0];
                    mem_wdata = comm_reg;
                end
            end
            S_READ:
            begin
                mem_raddr = idx_w[AW-1:0];
            end
            S_SORT_KEY:
            begin
                mem_raddr = i_reg[AW-1:0];
            end
            S_SORT_LOAD:
            begin
                mem_raddr = i_dec[AW-1:0];
            end
            S_SORT_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                if (cmp.gt)
                begin
                    mem_raddr = j_dec2[AW-1:0];
                end
                else
                begin
                    mem_wdata = comm_reg;
                end
            end
            S_SORT_PLACE:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = comm_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= CMD_CONTAINS;
            comm_reg   <= '0;
            idx_reg    <= '0;
            count_reg  <= '0;
            r_reg      <= '0;
            w_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            pend_reg   <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= ST_OK;
            entry_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        cmd_reg    <= req_cmd;
                        comm_reg   <= req_comm;
                        idx_reg    <= req_idx;
                        found_reg  <= 1'b0;
                        status_reg <= ST_OK;
                        entry_reg  <= '0;
                        r_reg      <= '0;
                        w_reg      <= '0;
                        pend_reg   <= 1'b0;
                        i_reg      <= CW'(1);
                        case (req_cmd) inside
                            CMD_CONTAINS, CMD_ADD, CMD_DELETE, CMD_STRIP:
                                state_reg <= S_SCAN;
                            CMD_SORT:
                                state_reg <= S_SORT_KEY;
                            CMD_READ:
                                state_reg <= S_READ;
                            CMD_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (issue)
                    begin
                        r_reg <= r_reg + CW'(1);
                    end
                    pend_reg <= issue;
                    if (pend_reg)
                    begin
                        if (cmp.eq)
                        begin
                            found_reg <= (cmd_reg != CMD_STRIP) ? 1'b1 : found_reg;
                        end
                        if (keep)
                        begin
                            w_reg <= w_reg + CW'(1);
                        end
                    end
                    if (!issue && !pend_reg)
                    begin
                        case (cmd_reg) inside
                            CMD_ADD:
                                state_reg <= S_ADD;
                            CMD_DELETE, CMD_STRIP:
                            begin
                                count_reg <= w_reg;
                                state_reg <= S_DONE;
                            end
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end
                S_ADD:
                begin
                    if (!found_reg)
                    begin
                        if (count_reg < CAP_C)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        else
                        begin
                            status_reg <= ST_FULL;
                        end
                    end
                    state_reg <= S_DONE;
                end
                S_READ:
                begin
                    if (idx_ok)
                    begin
                        state_reg <= S_READ_DATA;
                    end
                    else
                    begin
                        status_reg <= ST_RANGE;
                        state_reg  <= S_DONE;
                    end
                end
                S_READ_DATA:
                begin
                    entry_reg <= rd_data_reg;
                    state_reg <= S_DONE;
                end
                S_SORT_KEY:
                begin
                    state_reg <= (i_reg < count_reg) ? S_SORT_LOAD : S_DONE;
                end
                S_SORT_LOAD:
                begin
                    comm_reg  <= rd_data_reg;
                    j_reg     <= i_reg;
                    state_reg <= S_SORT_CMP;
                end
                S_SORT_CMP:
                begin
                    if (cmp.gt)
                    begin
                        j_reg <= j_dec;
                        if (j_dec == '0)
                        begin
                            state_reg <= S_SORT_PLACE;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_SORT_KEY;
                    end
                end
                S_SORT_PLACE:
                begin
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= S_SORT_KEY;
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
